FILE: rtl/mpfb_pkg.sv
// shared types, codes and the refresh microprogram for the page frame store
package mpfb_pkg;

  localparam int unsigned PAGE_W      = 3;
  localparam int unsigned COL_W       = 7;
  localparam int unsigned STORE_AW    = PAGE_W + COL_W;
  localparam int unsigned STORE_DEPTH = 1 << STORE_AW;
  localparam int unsigned UPC_W       = 4;

  typedef enum logic [1:0] {
    ACT_SET     = 2'd0,
    ACT_CLEAR   = 2'd1,
    ACT_START   = 2'd2,
    ACT_ADVANCE = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_STOP  = 2'd2
  } kind_t;

  // where the data byte of an element comes from
  typedef enum logic [2:0] {
    SRC_NONE  = 3'd0,
    SRC_ADDR  = 3'd1,
    SRC_CONST = 3'd2,
    SRC_PAGE  = 3'd3,
    SRC_STORE = 3'd4
  } src_t;

  // how the step counter moves after an element
  typedef enum logic [1:0] {
    OP_NEXT     = 2'd0,
    OP_COL_LOOP = 2'd1,
    OP_PAGE_END = 2'd2
  } seqop_t;

  typedef struct packed {
    kind_t      kind;
    src_t       src;
    logic [7:0] cbyte;
    seqop_t     op;
  } ucode_t;

  typedef struct packed {
    logic start;
    logic step;
  } seq_cmd_t;

  typedef struct packed {
    logic       busy;
    kind_t      kind;
    logic [7:0] data;
    logic       done;
  } seq_stat_t;

  // control words for the bus elements of a page; the column word repeats for every column
  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] step);
    ucode_t w;
    unique case (step)
      4'd0:    w = '{KIND_START, SRC_NONE,  8'h00, OP_NEXT};
      4'd1:    w = '{KIND_DATA,  SRC_ADDR,  8'h00, OP_NEXT};
      4'd2:    w = '{KIND_DATA,  SRC_CONST, 8'h00, OP_NEXT};
      4'd3:    w = '{KIND_DATA,  SRC_PAGE,  8'hB0, OP_NEXT};
      4'd4:    w = '{KIND_DATA,  SRC_CONST, 8'h10, OP_NEXT};
      4'd5:    w = '{KIND_DATA,  SRC_CONST, 8'h00, OP_NEXT};
      4'd6:    w = '{KIND_STOP,  SRC_NONE,  8'h00, OP_NEXT};
      4'd7:    w = '{KIND_START, SRC_NONE,  8'h00, OP_NEXT};
      4'd8:    w = '{KIND_DATA,  SRC_ADDR,  8'h00, OP_NEXT};
      4'd9:    w = '{KIND_DATA,  SRC_CONST, 8'h40, OP_NEXT};
      4'd10:   w = '{KIND_DATA,  SRC_STORE, 8'h00, OP_COL_LOOP};
      default: w = '{KIND_STOP,  SRC_NONE,  8'h00, OP_PAGE_END};
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/mpfb_useq.sv
// microcoded refresh sequencer: step counter, page and column counters
module mpfb_useq
  import mpfb_pkg::*;
#(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned PAGES = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  seq_cmd_t            cmd_i,
  input  logic [7:0]          dev_addr_i,
  input  logic [7:0]          store_byte_i,
  output seq_stat_t           stat_o,
  output logic [STORE_AW-1:0] rd_addr_o
);

  localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(WIDTH - 1);
  localparam logic [PAGE_W-1:0] PAGE_LAST = PAGE_W'(PAGES - 1);

  logic              busy_r, busy_nxt;
  logic [UPC_W-1:0]  upc_r, upc_nxt;
  logic [PAGE_W-1:0] page_r, page_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  ucode_t            uw;
  logic              last_page;

  assign uw        = ucode_rom(upc_r);
  assign last_page = (page_r == PAGE_LAST);
  assign rd_addr_o = {page_r, col_r};

  always_comb begin
    stat_o.busy = busy_r;
    stat_o.kind = uw.kind;
    stat_o.done = (uw.op == OP_PAGE_END) && last_page;
    case (uw.src)
      SRC_ADDR:  stat_o.data = dev_addr_i;
      SRC_CONST: stat_o.data = uw.cbyte;
      SRC_PAGE:  stat_o.data = uw.cbyte + {{(8-PAGE_W){1'b0}}, page_r};
      SRC_STORE: stat_o.data = store_byte_i;
      default:   stat_o.data = 8'h00;
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    upc_nxt  = upc_r;
    page_nxt = page_r;
    col_nxt  = col_r;
    if (cmd_i.start) begin
      busy_nxt = 1'b1;
      upc_nxt  = '0;
      page_nxt = '0;
      col_nxt  = '0;
    end else if (cmd_i.step && busy_r) begin
      unique case (uw.op)
        OP_NEXT: upc_nxt = upc_r + 1'b1;
        OP_COL_LOOP: begin
          if (col_r == COL_LAST) begin
            col_nxt = '0;
            upc_nxt = upc_r + 1'b1;
          end else begin
            col_nxt = col_r + 1'b1;
          end
        end
        OP_PAGE_END: begin
          upc_nxt = '0;
          if (last_page) begin
            busy_nxt = 1'b0;
            page_nxt = '0;
          end else begin
            page_nxt = page_r + 1'b1;
          end
        end
        default: upc_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      upc_r  <= '0;
      page_r <= '0;
      col_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      upc_r  <= upc_nxt;
      page_r <= page_nxt;
      col_r  <= col_nxt;
    end
  end

endmodule

FILE: rtl/mono_page_framebuffer_i2c_refresh.sv
// top level: page frame store with single-port memory and bus element sequencer
// set pixel, start refresh and advance each go through accept, then the execute state
// an advance holds the execute state while the previous element waits in the output register
// an advance result is loaded into the output register from the execute state and raises out_tvalid
// clear: accept, then one store byte a cycle on the single memory port
// reset is synchronous active low and runs the same clearing pass, in_tready low
module mono_page_framebuffer_i2c_refresh
  import mpfb_pkg::*;
#(
  parameter int unsigned WIDTH  = 128,
  parameter int unsigned HEIGHT = 64,
  parameter int unsigned PAGES  = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // request side
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // pixel_x[7:0], pixel_y[14:8], pixel_on[15]
  input  logic [1:0]  in_tuser,   // action[1:0]
  // bus element side
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // bus_byte[7:0]
  output logic [1:0]  out_tuser,  // element_kind[1:0]
  output logic        out_tlast,  // frame_done
  // device address register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  // one-hot controller states
  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  localparam logic [STORE_AW-1:0] CLR_LAST = STORE_AW'(STORE_DEPTH - 1);
  localparam logic [7:0]          X_LIM    = 8'(WIDTH);
  localparam logic [6:0]          Y_LIM    = 7'(HEIGHT);

  state_t              state_r, state_nxt;
  logic [STORE_AW-1:0] clr_cnt_r, clr_cnt_nxt;

  // latched request
  act_t                act_r;
  logic                pix_ok_r;
  logic                pix_on_r;
  logic [2:0]          bit_r;
  logic [STORE_AW-1:0] addr_r;

  logic [7:0]          dev_addr_r;

  // store port
  logic [7:0]          mem [STORE_DEPTH];
  logic [STORE_AW-1:0] mem_addr;
  logic                mem_we;
  logic [7:0]          mem_wdata;
  logic [7:0]          rdata_r;
  logic [7:0]          pix_byte;

  // output register
  logic                out_valid_r, out_valid_nxt;
  kind_t               out_kind_r;
  logic [7:0]          out_byte_r;
  logic                out_done_r;

  // request fields
  act_t                in_act;
  logic [7:0]          in_px;
  logic [6:0]          in_py;
  logic                in_on;
  logic                in_acc;
  logic [STORE_AW-1:0] in_addr;

  seq_cmd_t            seq_cmd;
  seq_stat_t           seq_stat;
  logic [STORE_AW-1:0] seq_addr;

  logic                needs_out;
  logic                out_free;
  logic                exec_done;
  logic                emit;

  assign in_act = act_t'(in_tuser);
  assign in_px  = in_tdata[7:0];
  assign in_py  = in_tdata[14:8];
  assign in_on  = in_tdata[15];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // an advance reads the column byte the sequencer points at, a set pixel its target byte
  assign in_addr = (in_act == ACT_ADVANCE) ? seq_addr : {in_py[5:3], in_px[6:0]};

  // read-modify-write of the pixel bit on the byte read at acceptance
  assign pix_byte = pix_on_r ? (rdata_r | (8'h01 << bit_r))
                             : (rdata_r & ~(8'h01 << bit_r));

  // an advance while refreshing needs the output register free before it completes
  assign needs_out = (act_r == ACT_ADVANCE) && seq_stat.busy;
  assign out_free  = !out_valid_r || out_tready;
  assign exec_done = !needs_out || out_free;
  assign emit      = (state_r == S_EXEC) && needs_out && out_free;

  assign seq_cmd.start = (state_r == S_EXEC) && (act_r == ACT_START);
  assign seq_cmd.step  = emit;

  mpfb_useq #(
    .WIDTH (WIDTH),
    .PAGES (PAGES)
  ) u_useq (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_i        (seq_cmd),
    .dev_addr_i   (dev_addr_r),
    .store_byte_i (rdata_r),
    .stat_o       (seq_stat),
    .rd_addr_o    (seq_addr)
  );

  // single store port: clearing sweep, request read, or execute-cycle write
  always_comb begin
    mem_addr  = in_addr;
    mem_we    = 1'b0;
    mem_wdata = pix_byte;
    unique case (state_r)
      S_CLEAR: begin
        mem_addr  = clr_cnt_r;
        mem_we    = 1'b1;
        mem_wdata = 8'h00;
      end
      S_IDLE: mem_addr = in_addr;
      S_EXEC: begin
        mem_addr = addr_r;
        mem_we   = (act_r == ACT_SET) && pix_ok_r;
      end
      default: mem_addr = in_addr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata_r <= mem[mem_addr];
  end

  // controller
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_act == ACT_CLEAR) begin
            state_nxt   = S_CLEAR;
            clr_cnt_nxt = '0;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        if (exec_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      dev_addr_r  <= 8'd120;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        dev_addr_r <= cfg_data;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r    <= in_act;
      pix_ok_r <= (in_px < X_LIM) && (in_py < Y_LIM);
      pix_on_r <= in_on;
      bit_r    <= in_py[2:0];
      addr_r   <= in_addr;
    end
    if (emit) begin
      out_kind_r <= seq_stat.kind;
      out_byte_r <= seq_stat.data;
      out_done_r <= seq_stat.done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_done_r;

  // an element is only produced while a refresh is running
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> seq_stat.busy)
    else $error("element emitted while sequencer idle");

  // a clear request blocks the request side for its sweep
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_act == ACT_CLEAR)) |=> !in_tready)
    else $error("request taken during clearing sweep");

  // store writes in the execute cycle come from set pixel only
  a_exec_write: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_EXEC) && mem_we) |-> (act_r == ACT_SET))
    else $error("unexpected store write");

  // the frame ends on a stop condition
  a_done_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tuser == KIND_STOP))
    else $error("frame end not on a stop");

endmodule

FILE: dv/mpfb_bus_checker.sv
// checker for the page frame store: predicts every bus element and compares it with the output
`timescale 1ns / 1ps
module mpfb_bus_checker
  import mpfb_pkg::*;
#(
  parameter int unsigned WIDTH  = 128,
  parameter int unsigned HEIGHT = 64,
  parameter int unsigned PAGES  = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [15:0] in_tdata,
  input  logic [1:0] in_tuser,
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,
  input  logic [1:0] out_tuser,
  input  logic       out_tlast,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [7:0] cfg_data,
  output int         mismatches,
  output int         elements_due
);

  localparam logic [7:0] CMD_ZERO      = 8'h00;
  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
  localparam logic [7:0] CTRL_DATA     = 8'h40;
  localparam logic [7:0] ADDR_RESET    = 8'd120;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } bus_elem_t;

  logic [7:0]  pixels [STORE_DEPTH];
  logic        armed;
  logic [2:0]  page;
  logic [7:0]  pos;
  logic [7:0]  dev_addr;
  bus_elem_t   elems_q [$];

  task automatic wipe_store();
    for (int i = 0; i < STORE_DEPTH; i++) pixels[i] = '0;
  endtask

  // updates the shadow state for one request and queues the element it causes, if any
  task automatic apply_request(act_t act, logic [7:0] x, logic [6:0] y, logic on);
    bus_elem_t           e;
    logic [STORE_AW-1:0] idx;
    e = '{KIND_START, CMD_ZERO, 1'b0};
    case (act)
      ACT_SET: begin
        if (x < WIDTH && y < HEIGHT) begin
          idx = {y[5:3], x[6:0]};
          pixels[idx][y[2:0]] = on;
        end
      end
      ACT_CLEAR: wipe_store();
      ACT_START: begin
        armed = 1'b1;
        page  = '0;
        pos   = '0;
      end
      ACT_ADVANCE: begin
        if (armed) begin
          case (pos) inside
            8'd0, 8'd7: e.kind = KIND_START;
            8'd6:       e.kind = KIND_STOP;
            8'd1, 8'd8: e = '{KIND_DATA, dev_addr, 1'b0};
            8'd2, 8'd5: e = '{KIND_DATA, CMD_ZERO, 1'b0};
            8'd3:       e = '{KIND_DATA, 8'(CMD_PAGE_BASE + page), 1'b0};
            8'd4:       e = '{KIND_DATA, CMD_COL_HIGH, 1'b0};
            8'd9:       e = '{KIND_DATA, CTRL_DATA, 1'b0};
            default: begin
              if (pos < 10 + WIDTH) begin
                idx = {page, 7'(pos - 8'd10)};
                e   = '{KIND_DATA, pixels[idx], 1'b0};
              end else begin
                e.kind = KIND_STOP;
              end
            end
          endcase
          if (pos >= 10 + WIDTH) begin
            pos = '0;
            if (page + 1 >= PAGES) begin
              e.last = 1'b1;
              armed  = 1'b0;
              page   = '0;
            end else begin
              page = page + 3'd1;
            end
          end else begin
            pos = pos + 8'd1;
          end
          elems_q.push_back(e);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    bus_elem_t got;
    bus_elem_t want;
    if (!rst_n) begin
      wipe_store();
      armed      = 1'b0;
      page       = '0;
      pos        = '0;
      dev_addr   = ADDR_RESET;
      mismatches = 0;
      elems_q.delete();
    end else begin
      // results first: no element can leave in the cycle its request is taken
      if (out_tvalid && out_tready) begin
        got = '{kind_t'(out_tuser), out_tdata, out_tlast};
        if (elems_q.size() == 0) begin
          $display("%0t unexpected element: kind %0d byte %02h last %0b",
                   $time, out_tuser, out_tdata, out_tlast);
          mismatches++;
        end else begin
          want = elems_q.pop_front();
          if (got !== want) begin
            $display({"%0t element mismatch: expected kind %0d byte %02h last %0b,",
                      " got kind %0d byte %02h last %0b"},
                     $time, want.kind, want.data, want.last, out_tuser, out_tdata, out_tlast);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) dev_addr = cfg_data;
      if (in_tvalid && in_tready)
        apply_request(act_t'(in_tuser), in_tdata[7:0], in_tdata[14:8], in_tdata[15]);
    end
    elements_due = elems_q.size();
  end

endmodule

FILE: dv/tb_mono_page_framebuffer_i2c_refresh.sv
// testbench top: stimulus, handshake idling and verdict for the page frame store refresh block
`timescale 1ns / 1ps
module tb_mono_page_framebuffer_i2c_refresh;
  import mpfb_pkg::*;

  localparam int unsigned WIDTH  = 128;
  localparam int unsigned HEIGHT = 64;
  localparam int unsigned PAGES  = 8;

  // bus elements in one page: 10 header elements, the columns, one stop
  localparam int PAGE_ELEMS     = WIDTH + 11;
  // two whole pages and the start of a third
  localparam int FRAME_ADVANCES = 2 * PAGE_ELEMS + 20;
  // a clear walks the whole store one byte a cycle
  localparam int CLEAR_CYCLES = STORE_DEPTH;
  localparam int HOLD_CYCLES  = 400;
  // cycles with no request moved on any channel before the run is declared hung
  localparam int STALL_LIMIT  = 8000;
  localparam int RANDOM_HALF  = 85;
  localparam int QUIET_TAIL   = 40;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // pixel_x[7:0], pixel_y[14:8], pixel_on[15]
  logic [1:0]  in_tuser;   // action[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // bus_byte[7:0]
  logic [1:0]  out_tuser;  // element_kind[1:0]
  logic        out_tlast;  // frame_done
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;

  int mismatches;
  int elements_due;

  // knobs for the stimulus and the sink, and the watchdog's idle count
  int gap_pct     = 30;
  bit quiet       = 1'b0;
  bit hold_req    = 1'b0;
  int idle_cycles = 0;

  mono_page_framebuffer_i2c_refresh #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT),
    .PAGES  (PAGES)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  mpfb_bus_checker #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT),
    .PAGES  (PAGES)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .elements_due (elements_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: any channel moving a request resets the count
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // element sink: random stall bursts in some stretches, none in others,
  // one long hold-off on request so the block backs up into its input
  initial begin
    bit stalls_on;
    int beat;
    out_tready = 1'b0;
    stalls_on  = 1'b1;
    beat       = 0;
    forever begin
      @(negedge clk);
      beat++;
      if (beat % 128 == 0) stalls_on = ($urandom_range(0, 2) != 0);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_tready <= 1'b1;
      end else if (!quiet && stalls_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // offers one request, maybe after an idle burst, and returns at the falling edge after it is taken;
  // tvalid is left high so back-to-back requests do not drop it in between unless an idle burst is drawn
  task automatic issue(act_t act, logic [7:0] x, logic [6:0] y, logic on);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {on, y, x};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // a random request: mostly advances and in-range pixels, some starts, clears and
  // out-of-range coordinates; the unused fields carry random bits as well
  task automatic random_request();
    int         pick;
    act_t       act;
    logic [7:0] x;
    logic [6:0] y;
    pick = $urandom_range(0, 99);
    x = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                    : 8'($urandom_range(0, WIDTH - 1));
    y = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                    : 7'($urandom_range(0, HEIGHT - 1));
    if (pick < 6)       act = ACT_START;
    else if (pick < 9)  act = ACT_CLEAR;
    else if (pick < 35) act = ACT_SET;
    else                act = ACT_ADVANCE;
    issue(act, x, y, 1'($urandom_range(0, 1)));
  endtask

  // drain everything in flight, give a clear still walking the store time to finish,
  // then write the device address while the block is quiet
  task automatic settle_and_write(logic [7:0] addr);
    in_tvalid <= 1'b0;
    while (elements_due != 0) @(negedge clk);
    repeat (CLEAR_CYCLES + 64) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= addr;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = ACT_SET;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed part, device address still at its reset value
    issue(ACT_SET, 8'd0, 7'd0, 1'b1);
    issue(ACT_SET, 8'd1, 7'd0, 1'b1);
    issue(ACT_SET, 8'(WIDTH - 1), 7'(HEIGHT - 1), 1'b1);
    issue(ACT_SET, 8'd2, 7'(HEIGHT - 1), 1'b1);
    issue(ACT_SET, 8'd2, 7'(HEIGHT - 1), 1'b0);  // bit cleared again
    issue(ACT_SET, 8'(WIDTH), 7'd0, 1'b1);       // column just past the edge, ignored
    issue(ACT_SET, 8'd0, 7'(HEIGHT), 1'b1);      // row just past the edge, ignored
    issue(ACT_SET, 8'hFF, 7'h7F, 1'b1);          // both coordinates at their maximum, ignored
    issue(ACT_ADVANCE, 8'hFF, 7'h7F, 1'b1);      // advance while idle gives nothing
    issue(ACT_START, 8'h00, 7'h00, 1'b0);
    // header of page 0 and the first two columns
    for (int n = 0; n < 12; n++) issue(ACT_ADVANCE, 8'($urandom), 7'($urandom), 1'($urandom));
    issue(ACT_CLEAR, 8'h00, 7'h00, 1'b0);        // clear in the middle of a refresh
    issue(ACT_SET, 8'd2, 7'd0, 1'b1);            // pixel written just ahead of its column
    issue(ACT_ADVANCE, 8'h00, 7'h00, 1'b0);
    issue(ACT_START, 8'h00, 7'h00, 1'b0);        // restart while busy
    issue(ACT_ADVANCE, 8'h00, 7'h00, 1'b0);

    // two pages and part of a third at the top address, pixels drawn while they are sent out
    settle_and_write(8'hFF);
    gap_pct = 20;
    issue(ACT_START, 8'h00, 7'h00, 1'b0);
    for (int n = 0; n < FRAME_ADVANCES; n++) begin
      if ($urandom_range(0, 5) == 0)
        issue(ACT_SET, 8'($urandom_range(0, WIDTH - 1)), 7'($urandom_range(0, HEIGHT - 1)),
              1'($urandom_range(0, 1)));
      if (n == FRAME_ADVANCES / 2) issue(ACT_CLEAR, 8'h00, 7'h00, 1'b0);
      issue(ACT_ADVANCE, 8'($urandom), 7'($urandom), 1'($urandom));
    end

    // random part at the bottom address, opening with a long sink hold-off
    settle_and_write(8'h00);
    gap_pct = 35;
    issue(ACT_START, 8'h00, 7'h00, 1'b0);
    @(posedge clk);
    hold_req = 1'b1;
    @(negedge clk);
    for (int n = 0; n < RANDOM_HALF; n++) random_request();

    // second random half at a random address, ending with no idling at all
    settle_and_write(8'($urandom_range(1, 254)));
    gap_pct = 25;
    issue(ACT_START, 8'h00, 7'h00, 1'b0);
    for (int n = 0; n < RANDOM_HALF; n++) begin
      if (n == RANDOM_HALF - QUIET_TAIL) quiet = 1'b1;
      random_request();
    end

    // drain, then a short tail to catch any stray element
    in_tvalid <= 1'b0;
    while (elements_due != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (mismatches == 0 && elements_due == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/mpfb_pkg.sv
rtl/mpfb_useq.sv
rtl/mono_page_framebuffer_i2c_refresh.sv
dv/mpfb_bus_checker.sv
dv/tb_mono_page_framebuffer_i2c_refresh.sv
